### design/frame_bitmap_allocator_macros.svh
// ----------------------------------------------------------------------------
// frame bitmap allocator assertion macros
// concurrent checks clocked on clk, held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef FRAME_BITMAP_ALLOCATOR_MACROS_SVH
`define FRAME_BITMAP_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define FBA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fba: same-cycle check failed");
// next-cycle implication
`define FBA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fba: next-cycle check failed");
`else
`define FBA_ASSERT_IMP(label, ante, cons)
`define FBA_ASSERT_NXT(label, ante, cons)
`endif
`endif

### design/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg
// shared widths, request codes and bit helpers of the frame bitmap allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fba_pkg;

  localparam int unsigned MODE_W     = 3;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned FCNT_W     = 16;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned FCNT_MAX   = 65535;
  localparam int unsigned FCNT_RESET = 32768;

  // request codes, code 7 is undefined and answered with ok low
  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR     = 3'd0,
    MODE_SET       = 3'd1,
    MODE_CLR_RANGE = 3'd2,
    MODE_SET_RANGE = 3'd3,
    MODE_TEST      = 3'd4,
    MODE_ALLOC     = 3'd5,
    MODE_ALLOC_RUN = 3'd6
  } mode_t;

  // index of the lowest set bit, isolated with x & -x then encoded
  function automatic logic [4:0] fba_lowest_one(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS-1:0] iso;
    logic [4:0]           idx;
    iso = v & (~v + 32'd1);
    idx = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      idx = idx | ({5{iso[j]}} & 5'(j));
    end
    return idx;
  endfunction

endpackage

### design/fba_in_if.sv
// ----------------------------------------------------------------------------
// fba_in_if
// request channel: valid/ready handshake carrying mode and addresses
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fba_in_if import fba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] end_addr;

  modport source (output valid, output mode, output addr, output end_addr, input ready);
  modport sink   (input valid, input mode, input addr, input end_addr, output ready);
endinterface

### design/fba_out_if.sv
// ----------------------------------------------------------------------------
// fba_out_if
// result channel: valid/ready handshake carrying address and flags
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fba_out_if import fba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] result_addr;
  logic              bit_set;
  logic              ok;

  modport source (output valid, output result_addr, output bit_set, output ok, input ready);
  modport sink   (input valid, input result_addr, input bit_set, input ok, output ready);
endinterface

### design/frame_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// frame_bitmap_allocator
// one used bit per page frame in a word memory with one write and one read port,
// walked by a small sequencer for set/clear/test, range updates and free-frame searches
// ----------------------------------------------------------------------------
// After reset the block sweeps the bitmap to zero, one word a cycle, and is
// not ready until the sweep has reached the last word; cfg writes are
// taken during the sweep. Then it takes one request word at a time. Each
// request with a known code passes PREP, SPAN, BOUND and START for bound
// setup. Set and clear then do one read-modify-write of a single bitmap
// word, and test only reads that word. Range updates read and then write
// each bitmap word touched, in turn. Free-frame and free-run searches stream
// one word per cycle through the read port. The result sits in an output
// register, so a waiting sink only delays the next request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "frame_bitmap_allocator_macros.svh"

module frame_bitmap_allocator import fba_pkg::*; #(
  parameter int unsigned MAX_FRAMES = 32768,
  parameter int unsigned RUN_WORDS  = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  fba_in_if.sink            in_ch,
  fba_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [FCNT_W-1:0] cfg_wdata
);

  localparam int unsigned MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW        = $clog2(MAP_WORDS);
  localparam int unsigned RCW       = $clog2(RUN_WORDS + 1);
  localparam int unsigned CLIP_I    = (MAX_FRAMES > FCNT_MAX) ? FCNT_MAX : MAX_FRAMES;
  localparam int unsigned RLIM_I    = (FCNT_RESET < CLIP_I) ? FCNT_RESET : CLIP_I;
  localparam logic [FCNT_W-1:0] LIM_CLIP  = FCNT_W'(CLIP_I);
  localparam logic [FCNT_W-1:0] RESET_LIM = FCNT_W'(RLIM_I);
  localparam logic [AW-1:0]     LAST_WORD = AW'(MAP_WORDS - 1);
  localparam logic [AW-1:0]     RUN_BACK  = AW'(RUN_WORDS - 1);
  localparam logic [RCW-1:0]    RUN_FULL  = RCW'(RUN_WORDS - 1);

  typedef enum logic [9:0] {
    S_CLR   = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_PREP  = 10'b00_0000_0100,
    S_SPAN  = 10'b00_0000_1000,
    S_BOUND = 10'b00_0001_0000,
    S_START = 10'b00_0010_0000,
    S_RD    = 10'b00_0100_0000,
    S_WR    = 10'b00_1000_0000,
    S_SCAN  = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [FCNT_W-1:0]   lim_r;
  logic [MODE_W-1:0]   mode_r;
  logic [ADDR_W-1:0]   addr_r, end_r;
  logic [ADDR_W:0]     diff_r, diff_nxt;
  logic [20:0]         span_r, span_nxt;
  logic [FCNT_W-1:0]   hi_r, hi_nxt;
  logic [FCNT_W-1:0]   hlast_r, hlast_nxt;
  logic [AW-1:0]       w_r, w_nxt;
  logic [AW-1:0]       ws_r, ws_nxt;
  logic [AW-1:0]       last_w_r, last_w_nxt;
  logic                issuing_r, issuing_nxt;
  logic                chk_v_r, chk_v_nxt;
  logic [AW-1:0]       chk_w_r, chk_w_nxt;
  logic                chk_last_r, chk_last_nxt;
  logic [RCW-1:0]      run_cnt_r, run_cnt_nxt;
  logic [ADDR_W-1:0]   res_addr_r, res_addr_nxt;
  logic                res_bit_r, res_bit_nxt;
  logic                res_ok_r, res_ok_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]   out_addr_r;
  logic                out_bit_r, out_ok_r;
  logic                out_load;

  // bitmap memory, one write and one registered read per cycle
  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] mem_rd_r;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa, mem_ra;
  logic [WORD_BITS-1:0] mem_wd;

  logic [19:0]          f0;
  logic [19:0]          lo;
  logic                 is_run, is_scan, is_set;
  logic [FCNT_W-1:0]    hi_m1;
  logic [4:0]           wr_lo_bit, wr_hi_bit;
  logic [WORD_BITS-1:0] wr_mask;
  logic [WORD_BITS-1:0] scan_pad, scan_free;
  logic [4:0]           free_idx;
  logic [AW-1:0]        run_start;

  assign f0      = addr_r[ADDR_W-1:PAGE_SHIFT];
  assign is_run  = (mode_r == MODE_ALLOC_RUN);
  assign is_scan = (mode_r == MODE_ALLOC) || is_run;
  assign is_set  = (mode_r == MODE_SET) || (mode_r == MODE_SET_RANGE);
  assign lo      = is_run ? 20'd0 : f0;
  assign hi_m1   = hi_r - 16'd1;

  // range mask for the word under read-modify-write
  assign wr_lo_bit = (w_r == ws_r) ? f0[4:0] : 5'd0;
  assign wr_hi_bit = (w_r == last_w_r) ? hlast_r[4:0] : 5'd31;
  assign wr_mask   = (32'hFFFF_FFFF << wr_lo_bit) & (32'hFFFF_FFFF >> (5'd31 - wr_hi_bit));

  // frames before the start and past the limit count as used
  assign scan_pad  = ((chk_w_r == ws_r) ? ~(32'hFFFF_FFFF << f0[4:0]) : '0)
                   | (chk_last_r ? ~(32'hFFFF_FFFF >> (5'd31 - hlast_r[4:0])) : '0);
  assign scan_free = ~(mem_rd_r | scan_pad);
  assign free_idx  = fba_lowest_one(scan_free);
  assign run_start = chk_w_r - RUN_BACK;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_addr = out_addr_r;
  assign out_ch.bit_set     = out_bit_r;
  assign out_ch.ok          = out_ok_r;

  always_comb begin
    state_nxt    = state_r;
    diff_nxt     = diff_r;
    span_nxt     = span_r;
    hi_nxt       = hi_r;
    hlast_nxt    = hlast_r;
    w_nxt        = w_r;
    ws_nxt       = ws_r;
    last_w_nxt   = last_w_r;
    issuing_nxt  = issuing_r;
    chk_v_nxt    = 1'b0;
    chk_w_nxt    = chk_w_r;
    chk_last_nxt = chk_last_r;
    run_cnt_nxt  = run_cnt_r;
    res_addr_nxt = res_addr_r;
    res_bit_nxt  = res_bit_r;
    res_ok_nxt   = res_ok_r;
    mem_we       = 1'b0;
    mem_wa       = w_r;
    mem_wd       = '0;
    mem_ra       = w_r;
    out_load     = 1'b0;

    unique case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        if (w_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end else begin
          w_nxt = w_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        diff_nxt     = {1'b0, end_r} - {1'b0, addr_r};
        res_addr_nxt = '0;
        res_bit_nxt  = 1'b0;
        res_ok_nxt   = 1'b1;
        case (mode_r) inside
          MODE_CLEAR, MODE_SET, MODE_CLR_RANGE, MODE_SET_RANGE,
          MODE_TEST, MODE_ALLOC, MODE_ALLOC_RUN: begin
            state_nxt = S_SPAN;
          end
          default: begin
            res_ok_nxt = 1'b0;
            state_nxt  = S_DONE;
          end
        endcase
      end
      S_SPAN: begin
        // exclusive end frame of the request before clipping at the limit
        case (mode_r) inside
          MODE_CLR_RANGE, MODE_SET_RANGE: begin
            if (!diff_r[ADDR_W] && (diff_r[ADDR_W-1:0] != '0)) begin
              span_nxt = {1'b0, f0} + 21'(diff_r[ADDR_W-1:PAGE_SHIFT])
                       + 21'(|diff_r[PAGE_SHIFT-1:0]);
            end else begin
              span_nxt = {1'b0, f0};
            end
          end
          MODE_ALLOC:     span_nxt = 21'(lim_r);
          MODE_ALLOC_RUN: span_nxt = 21'({lim_r[FCNT_W-1:5], 5'd0});
          default:        span_nxt = {1'b0, f0} + 21'd1;
        endcase
        state_nxt = S_BOUND;
      end
      S_BOUND: begin
        hi_nxt    = (span_r < 21'(lim_r)) ? span_r[FCNT_W-1:0] : lim_r;
        state_nxt = S_START;
      end
      S_START: begin
        if ({4'd0, hi_r} <= lo) begin
          res_ok_nxt = !is_scan;
          state_nxt  = S_DONE;
        end else begin
          hlast_nxt   = hi_m1;
          ws_nxt      = AW'(lo[FCNT_W-1:5]);
          w_nxt       = AW'(lo[FCNT_W-1:5]);
          last_w_nxt  = AW'(hi_m1[FCNT_W-1:5]);
          issuing_nxt = 1'b1;
          run_cnt_nxt = '0;
          state_nxt   = is_scan ? S_SCAN : S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_WR;
      end
      S_WR: begin
        if (mode_r == MODE_TEST) begin
          res_bit_nxt = mem_rd_r[f0[4:0]];
          state_nxt   = S_DONE;
        end else begin
          mem_we = 1'b1;
          mem_wd = is_set ? (mem_rd_r | wr_mask) : (mem_rd_r & ~wr_mask);
          if (w_r == last_w_r) begin
            state_nxt = S_DONE;
          end else begin
            w_nxt     = w_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_SCAN: begin
        // issue one read a cycle, check the word read the cycle before
        if (issuing_r) begin
          chk_v_nxt    = 1'b1;
          chk_w_nxt    = w_r;
          chk_last_nxt = (w_r == last_w_r);
          if (w_r == last_w_r) begin
            issuing_nxt = 1'b0;
          end else begin
            w_nxt = w_r + 1'b1;
          end
        end
        if (chk_v_r) begin
          if (is_run) begin
            if (mem_rd_r == '0) begin
              if (run_cnt_r == RUN_FULL) begin
                res_addr_nxt = ADDR_W'({run_start, 5'd0, 12'd0});
                state_nxt    = S_DONE;
              end else begin
                run_cnt_nxt = run_cnt_r + 1'b1;
                if (chk_last_r) begin
                  res_ok_nxt = 1'b0;
                  state_nxt  = S_DONE;
                end
              end
            end else begin
              run_cnt_nxt = '0;
              if (chk_last_r) begin
                res_ok_nxt = 1'b0;
                state_nxt  = S_DONE;
              end
            end
          end else begin
            if (scan_free != '0) begin
              res_addr_nxt = ADDR_W'({chk_w_r, free_idx, 12'd0});
              state_nxt    = S_DONE;
            end else if (chk_last_r) begin
              res_ok_nxt = 1'b0;
              state_nxt  = S_DONE;
            end
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      w_r         <= '0;
      lim_r       <= RESET_LIM;
      issuing_r   <= 1'b0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      w_r         <= w_nxt;
      issuing_r   <= issuing_nxt;
      chk_v_r     <= chk_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        lim_r <= (cfg_wdata < LIM_CLIP) ? cfg_wdata : LIM_CLIP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      mode_r <= in_ch.mode;
      addr_r <= in_ch.addr;
      end_r  <= in_ch.end_addr;
    end
    diff_r     <= diff_nxt;
    span_r     <= span_nxt;
    hi_r       <= hi_nxt;
    hlast_r    <= hlast_nxt;
    ws_r       <= ws_nxt;
    last_w_r   <= last_w_nxt;
    chk_w_r    <= chk_w_nxt;
    chk_last_r <= chk_last_nxt;
    run_cnt_r  <= run_cnt_nxt;
    res_addr_r <= res_addr_nxt;
    res_bit_r  <= res_bit_nxt;
    res_ok_r   <= res_ok_nxt;
    if (out_load) begin
      out_addr_r <= res_addr_r;
      out_bit_r  <= res_bit_r;
      out_ok_r   <= res_ok_r;
    end
  end

  `FBA_ASSERT_IMP(a_clr_writes_zero, state_r == S_CLR, mem_we && (mem_wd == '0))
  `FBA_ASSERT_NXT(a_accept_starts, in_ch.valid && in_ch.ready, state_r == S_PREP)
  `FBA_ASSERT_IMP(a_fail_zero_addr, out_valid_r && !out_ok_r, out_addr_r == '0)
  `FBA_ASSERT_IMP(a_scan_in_bounds, chk_v_r && (state_r == S_SCAN), chk_w_r <= last_w_r)
  `FBA_ASSERT_IMP(a_rmw_in_range, mem_we && (state_r == S_WR),
                  (w_r >= ws_r) && (w_r <= last_w_r))

endmodule
